/* design/jsu_pkg.sv */
// Shared types for the JSON string unescaper.
// Holds the command beat passed from the parser front end to the byte
// generator back end, and the result status codes. No dependencies.
package jsu_pkg;

    // Result status codes.
    localparam logic [1:0] ST_BYTE  = 2'd0;
    localparam logic [1:0] ST_CLOSE = 2'd1;
    localparam logic [1:0] ST_ERR   = 2'd2;

    // Main action of one command beat.
    typedef enum logic [2:0] {
        M_NONE,
        M_BYTE,
        M_CP,
        M_CLOSE,
        M_ERR
    } t_main;

    // One command: optionally the three bytes of a held high surrogate,
    // then the main action.
    typedef struct packed {
        logic        pre;
        logic [15:0] high;
        t_main       main;
        logic [20:0] val;
    } t_cmd;

    // Push port from the front end into the command queue.
    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_push;

endpackage

/* design/jsu_front.sv */
// Front end of the JSON string unescaper: accepts text beats, runs the
// parse state machine and issues one command beat per productive item.
// Depends on jsu_pkg.
module jsu_front
    import jsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_full,
    input  logic        i_kind,
    input  logic [7:0]  i_in_byte,
    output t_push       o_push
);

    typedef enum logic [3:0] {
        MODE_AWAIT,
        MODE_STR,
        MODE_ESC,
        MODE_HEX,
        MODE_HI,
        MODE_HI_ESC,
        MODE_HI_HEX,
        MODE_DONE,
        MODE_FAIL
    } t_mode;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    t_mode       r_mode, n_mode;
    logic [1:0]  r_cnt, n_cnt;
    logic [15:0] r_high, n_high;
    logic [15:0] r_low, n_low;
    t_cmd        cmd;
    logic        accept;
    logic        hex_ok;
    logic [3:0]  hex_d;
    logic        esc_ok;
    logic [7:0]  esc_b;
    logic [15:0] acc_hi;
    logic [15:0] acc_lo;

    // Hex digit decode, either case.
    always_comb begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (i_in_byte >= 8'h30 && i_in_byte <= 8'h39) begin
            hex_d = i_in_byte[3:0];
        end else if ((i_in_byte >= 8'h61 && i_in_byte <= 8'h66) ||
                     (i_in_byte >= 8'h41 && i_in_byte <= 8'h46)) begin
            hex_d = i_in_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    // Single-character escape table.
    always_comb begin
        esc_ok = 1'b1;
        case (i_in_byte)
            8'h22:   esc_b = 8'h22;
            8'h5C:   esc_b = 8'h5C;
            8'h2F:   esc_b = 8'h2F;
            8'h62:   esc_b = 8'h08;
            8'h66:   esc_b = 8'h0C;
            8'h6E:   esc_b = 8'h0A;
            8'h72:   esc_b = 8'h0D;
            8'h74:   esc_b = 8'h09;
            default: begin
                esc_b  = 8'h00;
                esc_ok = 1'b0;
            end
        endcase
    end

    assign acc_hi = {r_high[11:0], hex_d};
    assign acc_lo = {r_low[11:0], hex_d};
    assign accept = i_valid && !i_full;

    // Parse step: next state and the command for this beat.
    always_comb begin
        n_mode   = r_mode;
        n_cnt    = r_cnt;
        n_high   = r_high;
        n_low    = r_low;
        cmd.pre  = 1'b0;
        cmd.high = r_high;
        cmd.main = M_NONE;
        cmd.val  = 21'd0;
        if (i_kind) begin
            // End of text: report an unfinished string, then start over.
            case (r_mode)
                MODE_AWAIT, MODE_STR, MODE_ESC, MODE_HEX: begin
                    cmd.main = M_ERR;
                end
                MODE_HI, MODE_HI_ESC, MODE_HI_HEX: begin
                    cmd.pre  = 1'b1;
                    cmd.main = M_ERR;
                end
                default: begin
                end
            endcase
            n_mode = MODE_AWAIT;
            n_cnt  = 2'd0;
            n_high = 16'd0;
            n_low  = 16'd0;
        end else begin
            case (r_mode)
                MODE_AWAIT: begin
                    if (i_in_byte == CH_QUOTE) begin
                        n_mode = MODE_STR;
                    end else begin
                        cmd.main = M_ERR;
                        n_mode   = MODE_FAIL;
                    end
                end
                MODE_STR, MODE_HI: begin
                    if (r_mode == MODE_HI && i_in_byte == CH_BSL) begin
                        n_mode = MODE_HI_ESC;
                    end else begin
                        // A held high surrogate that is not followed by an
                        // escape goes out on its own first.
                        cmd.pre = (r_mode == MODE_HI);
                        if (i_in_byte == CH_QUOTE) begin
                            cmd.main = M_CLOSE;
                            n_mode   = MODE_DONE;
                        end else if (i_in_byte == CH_BSL) begin
                            n_mode = MODE_ESC;
                        end else begin
                            cmd.main = M_BYTE;
                            cmd.val  = {13'd0, i_in_byte};
                            n_mode   = MODE_STR;
                        end
                    end
                end
                MODE_ESC, MODE_HI_ESC: begin
                    if (i_in_byte == CH_U) begin
                        n_cnt = 2'd0;
                        if (r_mode == MODE_ESC) begin
                            n_mode = MODE_HEX;
                            n_high = 16'd0;
                        end else begin
                            n_mode = MODE_HI_HEX;
                            n_low  = 16'd0;
                        end
                    end else begin
                        cmd.pre = (r_mode == MODE_HI_ESC);
                        if (esc_ok) begin
                            cmd.main = M_BYTE;
                            cmd.val  = {13'd0, esc_b};
                            n_mode   = MODE_STR;
                        end else begin
                            cmd.main = M_ERR;
                            n_mode   = MODE_FAIL;
                        end
                    end
                end
                MODE_HEX: begin
                    if (!hex_ok) begin
                        cmd.main = M_ERR;
                        n_mode   = MODE_FAIL;
                    end else begin
                        n_high = acc_hi;
                        n_cnt  = r_cnt + 2'd1;
                        if (r_cnt == 2'd3) begin
                            if (acc_hi >= 16'hD800 && acc_hi <= 16'hDBFF) begin
                                n_mode = MODE_HI;
                            end else begin
                                cmd.main = M_CP;
                                cmd.val  = {5'd0, acc_hi};
                                n_mode   = MODE_STR;
                            end
                        end
                    end
                end
                MODE_HI_HEX: begin
                    if (!hex_ok) begin
                        cmd.pre  = 1'b1;
                        cmd.main = M_ERR;
                        n_mode   = MODE_FAIL;
                    end else begin
                        n_low = acc_lo;
                        n_cnt = r_cnt + 2'd1;
                        if (r_cnt == 2'd3) begin
                            if (acc_lo >= 16'hDC00 && acc_lo <= 16'hDFFF) begin
                                // Surrogate pair: one supplementary code point.
                                cmd.main = M_CP;
                                cmd.val  = 21'h10000 + {1'b0, r_high[9:0], acc_lo[9:0]};
                                n_mode   = MODE_STR;
                            end else begin
                                cmd.pre = 1'b1;
                                if (acc_lo >= 16'hD800 && acc_lo <= 16'hDBFF) begin
                                    n_high = acc_lo;
                                    n_mode = MODE_HI;
                                end else begin
                                    cmd.main = M_CP;
                                    cmd.val  = {5'd0, acc_lo};
                                    n_mode   = MODE_STR;
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_AWAIT;
            r_cnt  <= 2'd0;
            r_high <= 16'd0;
            r_low  <= 16'd0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_high <= n_high;
            r_low  <= n_low;
        end
    end

    // Only items that produce results are queued.
    assign o_push.push = accept && (cmd.pre || cmd.main != M_NONE);
    assign o_push.cmd  = cmd;

endmodule

/* design/jsu_queue.sv */
// Two-entry command queue between the parser front end and the byte
// generator back end. Depends on jsu_pkg.
module jsu_queue
    import jsu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_cmd  o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wp] <= i_push.cmd;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push.push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push.push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push.push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

/* design/jsu_back.sv */
// Back end of the JSON string unescaper: expands one command beat into
// up to six result beats held in a shift line. Depends on jsu_pkg.
module jsu_back
    import jsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_status,
    output logic        o_last
);

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } t_enc;

    // UTF-8 encoding of one code point.
    function automatic t_enc enc(input logic [20:0] cp);
        t_enc e;
        e.b = '0;
        if (cp <= 21'h7F) begin
            e.b[0] = cp[7:0];
            e.n    = 3'd1;
        end else if (cp <= 21'h7FF) begin
            e.b[0] = 8'hC0 | {3'd0, cp[10:6]};
            e.b[1] = 8'h80 | {2'd0, cp[5:0]};
            e.n    = 3'd2;
        end else if (cp <= 21'hFFFF) begin
            e.b[0] = 8'hE0 | {4'd0, cp[15:12]};
            e.b[1] = 8'h80 | {2'd0, cp[11:6]};
            e.b[2] = 8'h80 | {2'd0, cp[5:0]};
            e.n    = 3'd3;
        end else begin
            e.b[0] = 8'hF0 | {5'd0, cp[20:18]};
            e.b[1] = 8'h80 | {2'd0, cp[17:12]};
            e.b[2] = 8'h80 | {2'd0, cp[11:6]};
            e.b[3] = 8'h80 | {2'd0, cp[5:0]};
            e.n    = 3'd4;
        end
        return e;
    endfunction

    logic [7:0] r_byte [6];
    logic [1:0] r_stat [6];
    logic [2:0] r_cnt;
    logic [7:0] l_byte [6];
    logic [1:0] l_stat [6];
    logic [2:0] l_cnt;
    t_enc       hi_e;
    t_enc       main_e;
    logic [1:0] main_st;
    logic       take;
    logic       load;

    assign take  = (r_cnt != 3'd0) && !i_stall;
    assign load  = i_cmd_valid && ((r_cnt == 3'd0) || (r_cnt == 3'd1 && take));
    assign o_pop = load;

    // Main action of the command as a short byte list.
    always_comb begin
        hi_e    = enc({5'd0, i_cmd.high});
        main_e  = '0;
        main_st = ST_BYTE;
        case (i_cmd.main)
            M_BYTE: begin
                main_e.b[0] = i_cmd.val[7:0];
                main_e.n    = 3'd1;
            end
            M_CP: begin
                main_e = enc(i_cmd.val);
            end
            M_CLOSE: begin
                main_e.n = 3'd1;
                main_st  = ST_CLOSE;
            end
            M_ERR: begin
                main_e.n = 3'd1;
                main_st  = ST_ERR;
            end
            default: begin
            end
        endcase
    end

    // Beat list to load: held surrogate bytes first, then the main action.
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            l_byte[k] = 8'd0;
            l_stat[k] = ST_BYTE;
        end
        if (i_cmd.pre) begin
            for (int k = 0; k < 3; k++) begin
                l_byte[k]     = hi_e.b[k];
                l_byte[k + 3] = main_e.b[k];
                l_stat[k + 3] = main_st;
            end
            l_cnt = 3'd3 + main_e.n;
        end else begin
            for (int k = 0; k < 4; k++) begin
                l_byte[k] = main_e.b[k];
                l_stat[k] = main_st;
            end
            l_cnt = main_e.n;
        end
    end

    // Output shift line.
    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int k = 0; k < 6; k++) begin
                r_byte[k] <= l_byte[k];
                r_stat[k] <= l_stat[k];
            end
        end else if (take) begin
            for (int k = 0; k < 5; k++) begin
                r_byte[k] <= r_byte[k + 1];
                r_stat[k] <= r_stat[k + 1];
            end
        end
    end

    // Beat count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (load) begin
            r_cnt <= l_cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    assign o_valid    = (r_cnt != 3'd0);
    assign o_out_byte = r_byte[0];
    assign o_status   = r_stat[0];
    assign o_last     = (r_cnt == 3'd1);

endmodule

/* design/json_string_unescape_utf8_core.sv */
// JSON string unescaper to UTF-8, top level.
// Input channel: i_valid, o_stall, i_kind (0 = text byte, 1 = end of text),
// i_in_byte. A beat is taken on a clock edge with i_valid high and o_stall low.
// Output channel: o_valid, i_stall, o_out_byte, o_status (0 byte, 1 closed,
// 2 error), o_last marking the final result of one input beat.
// The parser takes one input beat per cycle while o_stall is low and writes a
// command into a two-entry queue; the back end turns each command into 1 to 6
// result beats, one per cycle while i_stall is low. With the back end idle, a
// beat's command is registered in the queue, then loaded into the output shift
// line. Throughput is one input beat per cycle while each beat yields at most
// one result and i_stall is low; a beat with more results holds the back end
// until its last result is taken; o_stall is high while the queue is full.
// Beats that give no result (opening quote, escape prefixes, hex digits that
// do not end a code point, bytes after close or error) are accepted without a command.
// A high i_stall holds the current result beat unchanged; the queue then
// fills and stalls the input. Synchronous reset (i_rst_n low) empties the
// queue and output and returns the parser to waiting for an opening quote.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
module json_string_unescape_utf8_core
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_kind,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status,
    output logic       o_last
);

    t_push push;
    logic  q_full;
    logic  q_valid;
    t_cmd  q_cmd;
    logic  pop;

    assign o_stall = q_full;

    // Parser.
    jsu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_full    (q_full),
        .i_kind    (i_kind),
        .i_in_byte (i_in_byte),
        .o_push    (push)
    );

    // Command queue.
    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Byte generator.
    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule
